// ----- rtl/core/h264_access_unit_splitter_defines.svh -----
// Assertion helpers shared by the checker.
`ifndef H264_ACCESS_UNIT_SPLITTER_DEFINES_SVH
`define H264_ACCESS_UNIT_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define H264AUS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h264aus check failed");

// Next-cycle implication, disabled while in reset.
`define H264AUS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h264aus check failed");

`endif

// ----- rtl/core/h264aus_pkg.sv -----
`timescale 1ns / 1ps
package h264aus_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [31:0] frame_offset;
        logic [23:0] frame_length;
        logic        truncated;
        logic [1:0]  result_kind;
    } out_item_t;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_LAST  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    localparam int          LEN_W           = 24;
    localparam logic [23:0] MAX_FRAME_RESET = 24'd524288;

    localparam int         CFG_ADDR_W     = 2;
    localparam logic [1:0] ADDR_MAX_FRAME = 2'd0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

// ----- rtl/core/h264aus_front.sv -----
`timescale 1ns / 1ps
module h264aus_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  h264aus_pkg::in_item_t      in_data,
    output logic                       ev_valid,
    input  logic                       ev_stall,
    output logic [OFFSET_BITS+33:0]    ev_data
);
    import h264aus_pkg::*;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] fso_reg, fso_next;
    logic [OFFSET_BITS-1:0] cand_reg, cand_next;
    logic [1:0]             zrun_reg, zrun_next;
    logic                   hdr_reg, hdr_next;
    logic                   pend_reg, pend_next;
    logic                   pic_reg, pic_next;
    logic                   emitted_reg, emitted_next;

    logic                   accept;
    logic                   boundary;
    logic                   is_pic;
    logic [1:0]             ev_kind;
    logic [31:0]            ev_start;
    logic [OFFSET_BITS-1:0] ev_len;
    logic [7:0]             b;

    assign accept   = in_valid && !ev_stall;
    assign in_stall = ev_stall;
    assign b        = in_data.data_byte;
    assign ev_data  = {ev_kind, ev_start, ev_len};

    always_comb
    begin
        pos_next     = pos_reg;
        fso_next     = fso_reg;
        cand_next    = cand_reg;
        zrun_next    = zrun_reg;
        hdr_next     = hdr_reg;
        pend_next    = pend_reg;
        pic_next     = pic_reg;
        emitted_next = emitted_reg;
        ev_valid     = 1'b0;
        ev_kind      = KIND_FRAME;
        ev_start     = 32'(fso_reg);
        ev_len       = cand_reg - fso_reg;
        boundary     = 1'b0;
        is_pic       = 1'b0;

        if (accept)
        begin
            if (in_data.end_of_stream)
            begin
                ev_valid = 1'b1;
                if (pic_reg && emitted_reg)
                begin
                    ev_kind = KIND_LAST;
                    ev_len  = pos_reg + OFFSET_BITS'(1) - fso_reg;
                end
                else
                begin
                    ev_kind  = KIND_ERROR;
                    ev_start = '0;
                    ev_len   = '0;
                end
                pos_next     = '0;
                fso_next     = '0;
                cand_next    = '0;
                zrun_next    = '0;
                hdr_next     = 1'b0;
                pend_next    = 1'b0;
                pic_next     = 1'b0;
                emitted_next = 1'b0;
            end
            else
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (b[7])
                    begin
                        // first_mb_in_slice == 0: picture start
                        boundary = 1'b1;
                        is_pic   = 1'b1;
                    end
                end
                else if (hdr_reg)
                begin
                    hdr_next = 1'b0;
                    case (b[4:0])
                        NAL_SEI, NAL_SPS, NAL_PPS: boundary  = 1'b1;
                        NAL_SLICE, NAL_IDR:        pend_next = 1'b1;
                        default:                   ;
                    endcase
                end

                if (boundary)
                begin
                    if (!pic_reg)
                    begin
                        if (is_pic)
                            pic_next = 1'b1;
                    end
                    else
                    begin
                        ev_valid     = 1'b1;
                        fso_next     = cand_reg;
                        pic_next     = is_pic;
                        emitted_next = 1'b1;
                    end
                end

                // start code found; long zero runs anchor on the third zero
                if (b == 8'd1 && zrun_reg >= 2'd2)
                begin
                    cand_next = pos_reg - ((zrun_reg == 2'd3) ? OFFSET_BITS'(3)
                                                              : OFFSET_BITS'(2));
                    hdr_next  = 1'b1;
                    pend_next = 1'b0;
                end

                if (b == 8'd0)
                    zrun_next = (zrun_reg == 2'd3) ? 2'd3 : zrun_reg + 2'd1;
                else
                    zrun_next = 2'd0;

                pos_next = pos_reg + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            fso_reg     <= '0;
            cand_reg    <= '0;
            zrun_reg    <= '0;
            hdr_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            pic_reg     <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            fso_reg     <= fso_next;
            cand_reg    <= cand_next;
            zrun_reg    <= zrun_next;
            hdr_reg     <= hdr_next;
            pend_reg    <= pend_next;
            pic_reg     <= pic_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// ----- rtl/core/h264aus_queue.sv -----
`timescale 1ns / 1ps
module h264aus_queue #(
    parameter int WIDTH = 66
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_stall,
    output logic [WIDTH-1:0] rd_data
);
    import h264aus_pkg::*;

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign wr_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        if (pop)
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/h264aus_back.sv -----
`timescale 1ns / 1ps
module h264aus_back #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_stall,
    input  logic [OFFSET_BITS+33:0] q_data,
    input  logic [23:0]             max_frame,
    output logic                    out_valid,
    input  logic                    out_stall,
    output h264aus_pkg::out_item_t  out_data
);
    import h264aus_pkg::*;

    localparam int CMP_W = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;

    logic [1:0]             q_kind;
    logic [31:0]            q_start;
    logic [OFFSET_BITS-1:0] q_len;
    logic                   trunc;
    logic                   load;
    logic                   valid_reg, valid_next;
    out_item_t              data_reg;
    out_item_t              data_next;

    assign {q_kind, q_start, q_len} = q_data;
    assign trunc   = CMP_W'(q_len) > CMP_W'(max_frame);
    assign load    = q_valid && (!valid_reg || !out_stall);
    assign q_stall = !load;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;

        data_next.frame_offset = q_start;
        data_next.frame_length = trunc ? max_frame : LEN_W'(q_len);
        data_next.truncated    = trunc;
        data_next.result_kind  = q_kind;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

// ----- rtl/core/h264_access_unit_splitter.sv -----
// An event enters the event queue as its byte is taken, then passes through the output register.
// Throughput: one byte per cycle; the scanner and the clip stage are split by a
// two-entry event queue, so a stalled output only blocks input once the queue is full.
// Reset: scan state and queue clear at once, max_frame returns to 524288;
// no clearing pass, the block takes bytes in the first cycle after reset.
`timescale 1ns / 1ps
module h264_access_unit_splitter #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  h264aus_pkg::in_item_t                in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output h264aus_pkg::out_item_t               out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [h264aus_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import h264aus_pkg::*;

    localparam int EV_W = OFFSET_BITS + 34;

    logic [23:0]     max_frame_reg;
    logic            cfg_wr;
    logic            ev_valid;
    logic            ev_stall;
    logic [EV_W-1:0] ev_data;
    logic            q_valid;
    logic            q_stall;
    logic [EV_W-1:0] q_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_FRAME);

    always_comb
    begin
        case (paddr)
            ADDR_MAX_FRAME: prdata = {8'd0, max_frame_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_reg <= MAX_FRAME_RESET;
        else if (cfg_wr)
            max_frame_reg <= pwdata[23:0];
    end

    h264aus_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .ev_valid (ev_valid),
        .ev_stall (ev_stall),
        .ev_data  (ev_data)
    );

    h264aus_queue #(
        .WIDTH(EV_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (ev_valid),
        .wr_stall (ev_stall),
        .wr_data  (ev_data),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_data  (q_data)
    );

    h264aus_back #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_data    (q_data),
        .max_frame (max_frame_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/core/h264aus_checker.sv -----
`timescale 1ns / 1ps
`include "h264_access_unit_splitter_defines.svh"
module h264aus_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  h264aus_pkg::out_item_t               out_data
);
    import h264aus_pkg::*;

    // a stalled result stays offered and unchanged
    `H264AUS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `H264AUS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    // error results carry no frame
    `H264AUS_ASSERT_NOW(a_err_empty, out_valid && out_data.result_kind == KIND_ERROR,
        out_data.frame_offset == '0 && out_data.frame_length == '0 && !out_data.truncated)
    `H264AUS_ASSERT_NOW(a_trunc_kind, out_valid && out_data.truncated,
        out_data.result_kind == KIND_FRAME || out_data.result_kind == KIND_LAST)

endmodule

bind h264_access_unit_splitter h264aus_checker u_h264aus_checker (.*);
